@@ sv/atm_pkg.sv @@
// Shared types and constants for the alarm table matcher.
// Used by atm_ctrl, atm_datapath and alarm_table_matcher_core.
`timescale 1ns / 1ps

package atm_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
    localparam logic [10:0] NO_MINUTE        = 11'd2047;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       repeat_flag;
        logic [2:0] entry_index;
        logic       clock_valid;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic       due;
        logic [2:0] due_index;
        logic [3:0] alarm_count;
    } t_out_item;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enabled;
        logic       rep;
    } t_alarm_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic ptr_clr;
        logic ptr_inc;
        logic rd_en;
        logic rd_next;
        logic wr_add;
        logic wr_back;
        logic wr_shift;
        logic cnt_inc;
        logic cnt_dec;
        logic last_upd;
        logic set_ok;
        logic set_due;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       idx_ok;
        logic       tick_go;
        logic       scan_end;
        logic       shift_end;
        logic       match;
        logic       out_busy;
    } t_status;

endpackage

@@ sv/atm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module atm_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/atm_ctrl.sv @@
// Sequencer for the alarm table: dispatch, match scan, shift-down on remove.
// Depends on atm_pkg for the state, command and status types.
`timescale 1ns / 1ps

module atm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  atm_pkg::t_status i_status,
    output atm_pkg::t_cmd    o_cmd
);

    atm_pkg::t_state r_state;
    atm_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            atm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = atm_pkg::S_DISPATCH;
            end
            atm_pkg::S_DISPATCH: begin
                case (i_status.kind)
                    atm_pkg::KIND_TICK:
                        n_state = i_status.tick_go ? atm_pkg::S_SCAN_RD : atm_pkg::S_DONE;
                    atm_pkg::KIND_REMOVE:
                        n_state = i_status.idx_ok ? atm_pkg::S_SHIFT_RD : atm_pkg::S_DONE;
                    default:
                        n_state = atm_pkg::S_DONE;
                endcase
            end
            atm_pkg::S_SCAN_RD: begin
                n_state = i_status.scan_end ? atm_pkg::S_DONE : atm_pkg::S_SCAN_CHK;
            end
            atm_pkg::S_SCAN_CHK: begin
                n_state = i_status.match ? atm_pkg::S_DONE : atm_pkg::S_SCAN_RD;
            end
            atm_pkg::S_SHIFT_RD: begin
                n_state = i_status.shift_end ? atm_pkg::S_DONE : atm_pkg::S_SHIFT_WR;
            end
            atm_pkg::S_SHIFT_WR: begin
                n_state = atm_pkg::S_SHIFT_RD;
            end
            atm_pkg::S_DONE: begin
                if (!i_status.out_busy) n_state = atm_pkg::S_IDLE;
            end
            default: n_state = atm_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            atm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            atm_pkg::S_DISPATCH: begin
                case (i_status.kind)
                    atm_pkg::KIND_TICK: begin
                        o_cmd.last_upd = i_status.tick_go;
                        o_cmd.ptr_clr  = i_status.tick_go;
                    end
                    atm_pkg::KIND_ADD: begin
                        o_cmd.wr_add  = !i_status.full;
                        o_cmd.cnt_inc = !i_status.full;
                        o_cmd.set_ok  = !i_status.full;
                    end
                    atm_pkg::KIND_REMOVE: begin
                        o_cmd.ptr_clr = i_status.idx_ok;
                        o_cmd.set_ok  = i_status.idx_ok;
                    end
                    default: ;
                endcase
            end
            atm_pkg::S_SCAN_RD: begin
                o_cmd.rd_en = !i_status.scan_end;
            end
            atm_pkg::S_SCAN_CHK: begin
                // a match rewrites the entry; one-shot alarms lose their enable
                o_cmd.set_due = i_status.match;
                o_cmd.wr_back = i_status.match;
                o_cmd.ptr_inc = !i_status.match;
            end
            atm_pkg::S_SHIFT_RD: begin
                o_cmd.cnt_dec = i_status.shift_end;
                o_cmd.rd_en   = !i_status.shift_end;
                o_cmd.rd_next = 1'b1;
            end
            atm_pkg::S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
            end
            atm_pkg::S_DONE: begin
                o_cmd.load_out = !i_status.out_busy;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/atm_datapath.sv @@
// Datapath of the alarm table: item latch, count, pointer, last minute,
// table RAM and the output register. Depends on atm_pkg and atm_ram.
`timescale 1ns / 1ps

module atm_datapath #(
    parameter int MAX_ALARMS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atm_pkg::t_in_item   i_in_data,
    input  atm_pkg::t_cmd       i_cmd,
    output atm_pkg::t_status    o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output atm_pkg::t_out_item  o_out_data
);

    localparam int CW = $clog2(MAX_ALARMS + 1);
    localparam int IW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int WW = (CW > 4) ? CW : 4;

    atm_pkg::t_in_item    r_item;
    atm_pkg::t_out_item   r_out;
    atm_pkg::t_alarm_entry rd_entry;
    atm_pkg::t_alarm_entry wr_entry;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic [10:0]   r_last;
    logic          r_ok;
    logic          r_due;
    logic [2:0]    r_which;
    logic          r_out_valid;

    logic [WW-1:0] cnt_w;
    logic [WW-1:0] ptr_w;
    logic [WW-1:0] ptr1_w;
    logic [WW-1:0] pos_w;
    logic [10:0]   mod;
    logic          out_busy;
    logic          we;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;

    assign cnt_w  = WW'(r_count);
    assign ptr_w  = WW'(r_ptr);
    assign ptr1_w = ptr_w + WW'(1);
    assign pos_w  = WW'(r_item.entry_index);
    assign mod    = 11'(r_item.hour) * atm_pkg::MINUTES_PER_HOUR + 11'(r_item.minute);
    assign out_busy = r_out_valid && !i_out_ready;

    // Status toward the controller
    always_comb begin
        o_status.kind      = r_item.kind;
        o_status.full      = cnt_w >= WW'(MAX_ALARMS);
        o_status.idx_ok    = pos_w < cnt_w;
        o_status.tick_go   = r_item.clock_valid && (mod != r_last);
        o_status.scan_end  = ptr_w >= cnt_w;
        o_status.shift_end = ptr1_w >= cnt_w;
        o_status.match     = rd_entry.enabled && (rd_entry.hour == r_item.hour)
                             && (rd_entry.minute == r_item.minute);
        o_status.out_busy  = out_busy;
    end

    // Table write and read address selection
    always_comb begin
        wr_entry = rd_entry;
        waddr    = ptr_w[IW-1:0];
        if (i_cmd.wr_add) begin
            wr_entry.hour    = r_item.hour;
            wr_entry.minute  = r_item.minute;
            wr_entry.enabled = 1'b1;
            wr_entry.rep     = r_item.repeat_flag;
            waddr            = cnt_w[IW-1:0];
        end else if (i_cmd.wr_back) begin
            wr_entry.enabled = rd_entry.rep;
        end
    end

    assign we    = i_cmd.wr_add || i_cmd.wr_back || i_cmd.wr_shift;
    assign raddr = i_cmd.rd_next ? ptr1_w[IW-1:0] : ptr_w[IW-1:0];

    atm_ram #(
        .WIDTH ($bits(atm_pkg::t_alarm_entry)),
        .DEPTH (MAX_ALARMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rd_entry)
    );

    // Item latch, pointer, result bits and output data (no reset needed)
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item  <= i_in_data;
            r_ok    <= 1'b0;
            r_due   <= 1'b0;
            r_which <= 3'd0;
        end
        if (i_cmd.set_ok)  r_ok <= 1'b1;
        if (i_cmd.set_due) begin
            r_due   <= 1'b1;
            r_which <= ptr_w[2:0];
        end
        if (i_cmd.ptr_clr) begin
            r_ptr <= (r_item.kind == atm_pkg::KIND_REMOVE) ? pos_w[CW-1:0] : '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end
        if (i_cmd.load_out) begin
            r_out.ok          <= r_ok;
            r_out.due         <= r_due;
            r_out.due_index   <= r_which;
            r_out.alarm_count <= cnt_w[3:0];
        end
    end

    // Entry count and last checked minute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= atm_pkg::NO_MINUTE;
        end else begin
            if (i_cmd.cnt_inc)       r_count <= r_count + CW'(1);
            else if (i_cmd.cnt_dec)  r_count <= r_count - CW'(1);
            if (i_cmd.last_upd)      r_last  <= mod;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_w <= WW'(MAX_ALARMS))
        else $error("entry count above table depth");

    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_add |-> (cnt_w < WW'(MAX_ALARMS)))
        else $error("add written into a full table");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !out_busy)
        else $error("result loaded over an untaken result");

    a_remove_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the table by one");

endmodule

@@ sv/alarm_table_matcher_core.sv @@
// Top level of the alarm table matcher: controller plus datapath.
// Depends on atm_pkg, atm_ctrl, atm_datapath (and atm_ram through it).
`timescale 1ns / 1ps

// Usage:
//   Input channel i_in_valid / o_in_ready / i_in_data carries one item: a
//   tick (clock time), an add, or a remove. Output channel o_out_valid /
//   i_out_ready / o_out_data returns exactly one result item per input item.
//   One item is in work at a time; o_in_ready is high only while idle.
//   Add, failed remove, ignored tick and unused kind go from dispatch
//   straight to the result. A tick that scans reads entries from index 0
//   until the first enabled match or the end of the table; a remove at
//   index p moves each entry above p down by one place, from p upward.
//   Scan and shift are paced by the table RAM: each entry takes a
//   registered read step and then a compare or write-back step.
//   The controller returns to idle after the result is loaded, so a new
//   item is accepted only once the last one is through.
//   If the receiver stalls, the result waits in the output register and
//   the next item is accepted and worked on; it completes only once the
//   waiting result is taken.
//   Synchronous active-low reset empties the table (count 0), forgets the
//   last checked minute and clears the output valid. No clearing pass.

module alarm_table_matcher_core #(
    parameter int MAX_ALARMS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  atm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output atm_pkg::t_out_item o_out_data
);

    atm_pkg::t_cmd    cmd;
    atm_pkg::t_status status;

    atm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    atm_datapath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/tb_alarm_table_matcher_core.sv @@
// Self-checking testbench for alarm_table_matcher_core: directed and random items
// are checked against a table model kept in a scoreboard class.
// Depends on atm_pkg and the alarm_table_matcher_core RTL.
`timescale 1ns / 1ps

// Scoreboard: mirrors the alarm table and queues the predicted reply per item
class alarm_scoreboard;
    localparam int TABLE_DEPTH = 8;

    atm_pkg::t_alarm_entry slots [TABLE_DEPTH];
    int                    entry_count;
    logic [10:0]           last_checked_minute;
    atm_pkg::t_out_item    pending_replies [$];
    int                    errors;

    function new();
        entry_count         = 0;
        last_checked_minute = atm_pkg::NO_MINUTE;
        errors              = 0;
        foreach (slots[i]) slots[i] = '0;
    endfunction

    // Apply one item to the mirrored table and return the reply it produces
    function atm_pkg::t_out_item table_step(atm_pkg::t_in_item it);
        atm_pkg::t_out_item r;
        logic [10:0]        day_minute;
        bit                 hit;
        r   = '0;
        hit = 0;
        case (it.kind)
            atm_pkg::KIND_TICK: begin
                day_minute = {6'd0, it.hour} * atm_pkg::MINUTES_PER_HOUR
                             + {5'd0, it.minute};
                if (it.clock_valid && day_minute != last_checked_minute) begin
                    last_checked_minute = day_minute;
                    for (int i = 0; i < entry_count; i++) begin
                        if (!hit && slots[i].enabled && slots[i].hour == it.hour &&
                            slots[i].minute == it.minute) begin
                            hit         = 1;
                            r.due       = 1'b1;
                            r.due_index = 3'(i);
                            // one-shot alarms go quiet after firing
                            if (!slots[i].rep) slots[i].enabled = 1'b0;
                        end
                    end
                end
            end
            atm_pkg::KIND_ADD: begin
                if (entry_count < TABLE_DEPTH) begin
                    slots[entry_count].hour    = it.hour;
                    slots[entry_count].minute  = it.minute;
                    slots[entry_count].enabled = 1'b1;
                    slots[entry_count].rep     = it.repeat_flag;
                    entry_count++;
                    r.ok = 1'b1;
                end
            end
            atm_pkg::KIND_REMOVE: begin
                if (int'(it.entry_index) < entry_count) begin
                    for (int i = int'(it.entry_index); i + 1 < entry_count; i++)
                        slots[i] = slots[i + 1];
                    entry_count--;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.alarm_count = 4'(entry_count);
        return r;
    endfunction

    function void note_item(atm_pkg::t_in_item it);
        pending_replies.push_back(table_step(it));
    endfunction

    function void check_result(atm_pkg::t_out_item got);
        atm_pkg::t_out_item want;
        if (pending_replies.size() == 0) begin
            $error("result item with no item outstanding: %h", got);
            errors++;
            return;
        end
        want = pending_replies.pop_front();
        if (got.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok);
            errors++;
        end
        if (got.due !== want.due) begin
            $error("due: expected %0d, actual %0d", want.due, got.due);
            errors++;
        end
        if (got.due_index !== want.due_index) begin
            $error("due_index: expected %0d, actual %0d", want.due_index, got.due_index);
            errors++;
        end
        if (got.alarm_count !== want.alarm_count) begin
            $error("alarm_count: expected %0d, actual %0d", want.alarm_count,
                   got.alarm_count);
            errors++;
        end
    endfunction

    function int pending();
        return pending_replies.size();
    endfunction
endclass

module tb_alarm_table_matcher_core;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 552;
    localparam int         PHASES       = 4;
    localparam int         POOL_SIZE    = 6;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    atm_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    atm_pkg::t_out_item o_out_data;

    alarm_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;

    // alarm times shared by adds and ticks so that matches actually happen
    logic [4:0] pool_hour   [POOL_SIZE];
    logic [5:0] pool_minute [POOL_SIZE];

    alarm_table_matcher_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic atm_pkg::t_in_item make_item(logic [1:0] kind, logic [4:0] hour,
                                                    logic [5:0] minute, logic rep,
                                                    logic [2:0] idx, logic cv);
        atm_pkg::t_in_item it;
        it.kind        = kind;
        it.hour        = hour;
        it.minute      = minute;
        it.repeat_flag = rep;
        it.entry_index = idx;
        it.clock_valid = cv;
        return it;
    endfunction

    task automatic refresh_pool();
        foreach (pool_hour[i]) begin
            if ($urandom_range(9) == 0) begin
                pool_hour[i]   = 5'($urandom);
                pool_minute[i] = 6'($urandom);
            end else begin
                pool_hour[i]   = 5'($urandom_range(23));
                pool_minute[i] = 6'($urandom_range(59));
            end
        end
    endtask

    // Mostly well-formed traffic; unused fields carry random bits
    function automatic atm_pkg::t_in_item random_item();
        atm_pkg::t_in_item it;
        logic [31:0]       raw;
        int                sel;
        int                p;
        raw = $urandom;
        it  = raw[$bits(atm_pkg::t_in_item)-1:0];
        sel = $urandom_range(99);
        p   = $urandom_range(POOL_SIZE - 1);
        if (sel < 45) begin
            it.kind        = atm_pkg::KIND_TICK;
            it.clock_valid = ($urandom_range(9) != 0);
            if ($urandom_range(9) != 0) begin
                it.hour   = pool_hour[p];
                it.minute = pool_minute[p];
            end
        end else if (sel < 72) begin
            it.kind = atm_pkg::KIND_ADD;
            if ($urandom_range(6) != 0) begin
                it.hour   = pool_hour[p];
                it.minute = pool_minute[p];
            end
        end else if (sel < 95) begin
            it.kind = atm_pkg::KIND_REMOVE;
            if (sb.entry_count > 0 && $urandom_range(4) != 0)
                it.entry_index = 3'($urandom_range(sb.entry_count - 1));
        end else begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // Present one item, with an optional idle gap first, and wait for acceptance
    task automatic send_item(atm_pkg::t_in_item it);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
    endtask

    initial begin
        atm_pkg::t_in_item directed [$];
        int                waited;

        refresh_pool();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, stopped clock, repeated minute, bad remove
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd0,  6'd0,  1'b0, 3'd0, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd0,  6'd0,  1'b0, 3'd0, 1'b1));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd0,  6'd0,  1'b1, 3'd7, 1'b1));
        directed.push_back(make_item(atm_pkg::KIND_REMOVE, 5'd31, 6'd63, 1'b1, 3'd0, 1'b1));
        // extreme and out-of-range times, duplicate alarm with different repeat
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd0,  6'd0,  1'b1, 3'd7, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd31, 6'd63, 1'b0, 3'd0, 1'b1));
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd23, 6'd59, 1'b0, 3'd5, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd23, 6'd59, 1'b1, 3'd2, 1'b1));
        // one-shot fires and disables, then the repeat copy takes over
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd23, 6'd59, 1'b0, 3'd0, 1'b1));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd23, 6'd59, 1'b0, 3'd0, 1'b1));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd31, 6'd63, 1'b1, 3'd3, 1'b1));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd23, 6'd59, 1'b0, 3'd0, 1'b1));
        directed.push_back(make_item(KIND_UNUSED,          5'd31, 6'd63, 1'b1, 3'd7, 1'b1));
        // fill to capacity, then overflow
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd12, 6'd30, 1'b0, 3'd0, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd1,  6'd1,  1'b1, 3'd0, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd5,  6'd5,  1'b0, 3'd0, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd7,  6'd7,  1'b1, 3'd0, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_ADD,    5'd0,  6'd0,  1'b0, 3'd0, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd0,  6'd0,  1'b0, 3'd0, 1'b1));
        // remove last, first, then an index past the end
        directed.push_back(make_item(atm_pkg::KIND_REMOVE, 5'd0,  6'd0,  1'b0, 3'd7, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_REMOVE, 5'd0,  6'd0,  1'b0, 3'd0, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_REMOVE, 5'd0,  6'd0,  1'b0, 3'd6, 1'b0));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd5,  6'd5,  1'b0, 3'd0, 1'b1));
        directed.push_back(make_item(atm_pkg::KIND_TICK,   5'd1,  6'd1,  1'b0, 3'd0, 1'b1));
        foreach (directed[i]) send_item(directed[i]);

        // random traffic under each idling mix
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 68; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (n % 40 == 0) refresh_pool();
                send_item(random_item());
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        waited = 0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $error("%0d expected result items never arrived", sb.pending());
            sb.errors++;
        end
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/atm_pkg.sv
sv/atm_ram.sv
sv/atm_ctrl.sv
sv/atm_datapath.sv
sv/alarm_table_matcher_core.sv
verif/tb_alarm_table_matcher_core.sv
